// ----- sv/frefl_pkg.sv -----
// fresnel reflectance package: payload structs and fixed-point constants
// used by the top level and its testbench; depends on nothing

`default_nettype none

package frefl_pkg;

  // fraction bits of vectors and of the reflectance
  localparam int FracBitsDef = 15;
  // working precision of cosines, sines and ratios
  localparam int Wq = 30;
  // index of refraction of the outside medium, q4.12
  localparam logic [15:0] EtaOne = 16'd4096;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [15:0]        ior;
  } frefl_in_t;

  typedef struct packed {
    logic [15:0] reflectance;
    logic        total_internal;
  } frefl_res_t;

endpackage

`default_nettype wire

// ----- sv/frefl_sqrt_pipe.sv -----
// pipelined integer square root, one result bit per register stage
// sideband travels alongside; no package dependency

`default_nettype none

module frefl_sqrt_pipe #(
  parameter int N  = 31,
  parameter int SW = 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire logic [2*N-2:0]  x_i,
  input  wire logic [SW-1:0]   side_i,
  output logic                 valid_o,
  output logic [N-1:0]         root_o,
  output logic [SW-1:0]        side_o
);

  localparam int XW = 2 * N - 1;

  logic [N-1:0]  v_q;
  logic [XW-1:0] x_q [N];
  logic [XW-1:0] r_q [N];
  logic [SW-1:0] s_q [N];

  for (genvar k = 0; k < N; k++) begin : g_st
    localparam logic [XW-1:0] Bit = {{(XW-1){1'b0}}, 1'b1} << (2 * (N - 1 - k));
    logic [XW-1:0] xin, rin, t, x_d, r_d;
    logic [SW-1:0] sin;
    logic          vin;

    if (k == 0) begin : g_first
      assign xin = x_i;
      assign rin = '0;
      assign sin = side_i;
      assign vin = valid_i;
    end else begin : g_next
      assign xin = x_q[k-1];
      assign rin = r_q[k-1];
      assign sin = s_q[k-1];
      assign vin = v_q[k-1];
    end

    always_comb begin
      t = rin + Bit;
      if (xin >= t) begin
        x_d = xin - t;
        r_d = (rin >> 1) + Bit;
      end else begin
        x_d = xin;
        r_d = rin >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      x_q[k] <= x_d;
      r_q[k] <= r_d;
      s_q[k] <= sin;
    end
  end

  assign valid_o = v_q[N-1];
  assign root_o  = r_q[N-1][N-1:0];
  assign side_o  = s_q[N-1];

endmodule

`default_nettype wire

// ----- sv/frefl_div_pipe.sv -----
// pipelined restoring divider, one quotient bit per register stage
// needs num < den << QW; sideband travels alongside; no package dependency

`default_nettype none

module frefl_div_pipe #(
  parameter int DW = 16,
  parameter int QW = 30,
  parameter int SW = 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire logic [DW+QW-1:0] num_i,
  input  wire logic [DW-1:0]    den_i,
  input  wire logic [SW-1:0]    side_i,
  output logic                  valid_o,
  output logic [QW-1:0]         quot_o,
  output logic [SW-1:0]         side_o
);

  localparam int W = DW + QW;

  logic [QW-1:0] v_q;
  logic [W-1:0]  rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [SW-1:0] s_q   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_st
    logic [W-1:0]  rin, dsh, rem_d;
    logic [DW-1:0] din;
    logic [QW-1:0] qin, quo_d;
    logic [SW-1:0] sin;
    logic          vin;

    if (k == 0) begin : g_first
      assign rin = num_i;
      assign din = den_i;
      assign qin = '0;
      assign sin = side_i;
      assign vin = valid_i;
    end else begin : g_next
      assign rin = rem_q[k-1];
      assign din = den_q[k-1];
      assign qin = quo_q[k-1];
      assign sin = s_q[k-1];
      assign vin = v_q[k-1];
    end

    always_comb begin
      dsh = W'(din) << (QW - 1 - k);
      if (rin >= dsh) begin
        rem_d = rin - dsh;
        quo_d = (qin << 1) | QW'(1);
      end else begin
        rem_d = rin;
        quo_d = qin << 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= rem_d;
      den_q[k] <= din;
      quo_q[k] <= quo_d;
      s_q[k]   <= sin;
    end
  end

  assign valid_o = v_q[QW-1];
  assign quot_o  = quo_q[QW-1];
  assign side_o  = s_q[QW-1];

endmodule

`default_nettype wire

// ----- sv/fresnel_reflectance_unit.sv -----
// unpolarised dielectric fresnel reflectance, fully pipelined top level
// uses frefl_pkg, frefl_sqrt_pipe and frefl_div_pipe
//
//   channel   | handshake        | payload
//   ----------+------------------+--------------------------------
//   command   | start, busy      | in_i  (direction, normal, ior)
//   result    | done_o strobe    | res_o (reflectance, total_internal)
//
// one transfer is taken every cycle; busy stays low
// the stages are three front stages, two square roots of 31 steps,
//   a 30-step and two parallel 31-step dividers, and seven glue stages
// reset clears only the valid bits of the stages; payload is not reset
// results appear for one cycle on done_o and cannot be held off

`default_nettype none

module fresnel_reflectance_unit #(
  parameter int FRAC_BITS = frefl_pkg::FracBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire frefl_pkg::frefl_in_t in_i,
  output logic                      done_o,
  output frefl_pkg::frefl_res_t     res_o
);

  localparam int Wq  = frefl_pkg::Wq;
  localparam int Sh  = 2 * FRAC_BITS - Wq;
  localparam int Shr = (Sh > 0) ? Sh : 0;
  localparam int Shl = (Sh < 0) ? -Sh : 0;
  localparam logic [63:0] Lim  = 64'd1 << (2 * FRAC_BITS);
  localparam logic [63:0] Half = 64'd1 << (60 - FRAC_BITS);
  localparam logic [63:0] SatW = ((64'd1 << FRAC_BITS) > 64'd65535) ? 64'd65535
                                 : (64'd1 << FRAC_BITS);
  localparam logic [30:0] One  = 31'd1 << Wq;

  // the pipeline never stalls
  assign busy = 1'b0;

  // stage 1: dot-product terms, ior of zero counts as one lsb
  logic              v1_q;
  logic signed [31:0] p0_q, p1_q, p2_q;
  logic [15:0]       ior_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    p0_q  <= in_i.dir_x * in_i.normal_x;
    p1_q  <= in_i.dir_y * in_i.normal_y;
    p2_q  <= in_i.dir_z * in_i.normal_z;
    ior_q <= (in_i.ior == 16'd0) ? 16'd1 : in_i.ior;
  end

  // stage 2: sum, clamp to one, bring to q30, pick the indices
  logic signed [33:0] dsum;
  logic [33:0]        mag;
  logic [63:0]        mag_w, cs_w;
  logic [30:0]        c_d;
  logic               exiting;

  always_comb begin
    dsum    = 34'(p0_q) + 34'(p1_q) + 34'(p2_q);
    exiting = !dsum[33] && (dsum != 34'sd0);
    mag     = dsum[33] ? 34'(-dsum) : 34'(dsum);
    mag_w   = 64'(mag);
    if (mag_w > Lim) begin
      mag_w = Lim;
    end
    cs_w = (mag_w >> Shr) << Shl;
    c_d  = (cs_w > 64'(One)) ? One : cs_w[30:0];
  end

  logic        v2_q;
  logic [30:0] c2s_q;
  logic [15:0] etai_2q, etat_2q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c2s_q   <= c_d;
    etai_2q <= exiting ? ior_q : frefl_pkg::EtaOne;
    etat_2q <= exiting ? frefl_pkg::EtaOne : ior_q;
  end

  // stage 3: cosine squared
  logic [61:0] csq;
  assign csq = 62'(c2s_q) * 62'(c2s_q);

  logic        v3_q;
  logic [30:0] c_3q, csq_3q;
  logic [15:0] etai_3q, etat_3q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_3q    <= c2s_q;
    csq_3q  <= csq[60:30];
    etai_3q <= etai_2q;
    etat_3q <= etat_2q;
  end

  // sine of incidence
  logic [60:0] x1;
  logic [62:0] sd1_in, sd1_out;
  logic        vs1;
  logic [30:0] sin_i;
  assign x1     = {One - csq_3q, 30'd0};
  assign sd1_in = {c_3q, etai_3q, etat_3q};

  frefl_sqrt_pipe #(.N(31), .SW(63)) u_sqrt_sin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .x_i     (x1),
    .side_i  (sd1_in),
    .valid_o (vs1),
    .root_o  (sin_i),
    .side_o  (sd1_out)
  );

  // stage 4: snell numerator
  logic        v4_q;
  logic [46:0] m_4q;
  logic [62:0] sd_4q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= vs1;
    end
  end

  always_ff @(posedge clk_i) begin
    m_4q  <= 47'(sin_i) * 47'(sd1_out[31:16]);
    sd_4q <= sd1_out;
  end

  // stage 5: total internal reflection when the quotient reaches one
  logic        v5_q, tir_5q;
  logic [45:0] m_5q;
  logic [62:0] sd_5q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tir_5q <= m_4q >= {1'b0, sd_4q[15:0], 30'd0};
    m_5q   <= m_4q[45:0];
    sd_5q  <= sd_4q;
  end

  // transmitted sine
  logic [63:0] dv1_out;
  logic        vd1;
  logic [29:0] sin_t;

  frefl_div_pipe #(.DW(16), .QW(30), .SW(64)) u_div_snell (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v5_q),
    .num_i   (m_5q),
    .den_i   (sd_5q[15:0]),
    .side_i  ({tir_5q, sd_5q}),
    .valid_o (vd1),
    .quot_o  (sin_t),
    .side_o  (dv1_out)
  );

  // stage 6: transmitted sine squared
  logic [59:0] ssq;
  assign ssq = 60'(sin_t) * 60'(sin_t);

  logic        v6_q;
  logic [29:0] ssq_6q;
  logic [63:0] sd_6q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else begin
      v6_q <= vd1;
    end
  end

  always_ff @(posedge clk_i) begin
    ssq_6q <= ssq[59:30];
    sd_6q  <= dv1_out;
  end

  // transmitted cosine
  logic [60:0] x2;
  logic [63:0] sd2_out;
  logic        vs2;
  logic [30:0] cos_t;
  assign x2 = {One - 31'(ssq_6q), 30'd0};

  frefl_sqrt_pipe #(.N(31), .SW(64)) u_sqrt_cos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v6_q),
    .x_i     (x2),
    .side_i  (sd_6q),
    .valid_o (vs2),
    .root_o  (cos_t),
    .side_o  (sd2_out)
  );

  // stage 7: index-weighted cosines
  logic [30:0] c_s2;
  logic [15:0] etai_s2, etat_s2;
  logic [46:0] as_p, bs_p, ap_p, bp_p;
  assign c_s2    = sd2_out[62:32];
  assign etai_s2 = sd2_out[31:16];
  assign etat_s2 = sd2_out[15:0];
  assign as_p    = 47'(etat_s2) * 47'(c_s2);
  assign bs_p    = 47'(etai_s2) * 47'(cos_t);
  assign ap_p    = 47'(etai_s2) * 47'(c_s2);
  assign bp_p    = 47'(etat_s2) * 47'(cos_t);

  logic        v7_q, tir_7q;
  logic [45:0] as_7q, bs_7q, ap_7q, bp_7q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else begin
      v7_q <= vs2;
    end
  end

  always_ff @(posedge clk_i) begin
    tir_7q <= sd2_out[63];
    as_7q  <= as_p[45:0];
    bs_7q  <= bs_p[45:0];
    ap_7q  <= ap_p[45:0];
    bp_7q  <= bp_p[45:0];
  end

  // stage 8: ratio numerators and denominators
  logic        v8_q, tir_8q, dzs_8q, dzp_8q;
  logic [46:0] ns_8q, ds_8q, np_8q, dp_8q;
  logic [46:0] ds_d, dp_d;
  assign ds_d = 47'(as_7q) + 47'(bs_7q);
  assign dp_d = 47'(ap_7q) + 47'(bp_7q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v8_q <= 1'b0;
    end else begin
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tir_8q <= tir_7q;
    ns_8q  <= (as_7q >= bs_7q) ? 47'(as_7q - bs_7q) : 47'(bs_7q - as_7q);
    np_8q  <= (ap_7q >= bp_7q) ? 47'(ap_7q - bp_7q) : 47'(bp_7q - ap_7q);
    ds_8q  <= ds_d;
    dp_8q  <= dp_d;
    dzs_8q <= ds_d == 47'd0;
    dzp_8q <= dp_d == 47'd0;
  end

  // s- and p-polarised amplitude ratios, in parallel
  logic [1:0]  dvs_out;
  logic        dvp_out, vds, vdp;
  logic [30:0] rs_q30, rp_q30;

  frefl_div_pipe #(.DW(47), .QW(31), .SW(2)) u_div_rs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v8_q),
    .num_i   (78'(ns_8q) << Wq),
    .den_i   (ds_8q),
    .side_i  ({tir_8q, dzs_8q}),
    .valid_o (vds),
    .quot_o  (rs_q30),
    .side_o  (dvs_out)
  );

  frefl_div_pipe #(.DW(47), .QW(31), .SW(1)) u_div_rp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v8_q),
    .num_i   (78'(np_8q) << Wq),
    .den_i   (dp_8q),
    .side_i  (dzp_8q),
    .valid_o (vdp),
    .quot_o  (rp_q30),
    .side_o  (dvp_out)
  );

  // stage 9: squares, a zero denominator gives a ratio of one
  logic [30:0] rs, rp;
  assign rs = dvs_out[0] ? One : rs_q30;
  assign rp = dvp_out    ? One : rp_q30;

  logic        v9_q, tir_9q;
  logic [61:0] sqs_9q, sqp_9q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v9_q <= 1'b0;
    end else begin
      v9_q <= vds & vdp;
    end
  end

  always_ff @(posedge clk_i) begin
    tir_9q <= dvs_out[1];
    sqs_9q <= 62'(rs) * 62'(rs);
    sqp_9q <= 62'(rp) * 62'(rp);
  end

  // stage 10: halve, round to nearest, saturate; total internal reflection also saturates
  logic [63:0] rnd, refl;
  always_comb begin
    rnd  = 64'(sqs_9q) + 64'(sqp_9q) + Half;
    refl = rnd >> (61 - FRAC_BITS);
    if (tir_9q || (refl > SatW)) begin
      refl = SatW;
    end
  end

  logic       done_q;
  frefl_pkg::frefl_res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v9_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.reflectance    <= refl[15:0];
    res_q.total_internal <= tir_9q;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

// ----- tb/sv/tb_fresnel_reflectance_unit.sv -----
// self-checking testbench for fresnel_reflectance_unit
// uses frefl_pkg; predicts every reflectance in fixed point and compares each result strobe

`default_nettype none

module tb_fresnel_reflectance_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import frefl_pkg::*;

  localparam int unsigned IdleLimit = 2000;  // cycles with no transfer before giving up
  localparam int unsigned Drain     = 200;   // wait after the last expected result for any stray strobe

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  frefl_in_t  in_i;
  logic       done_o;
  frefl_res_t res_o;

  frefl_in_t  pending_cmds[$];     // commands not yet sent
  frefl_res_t expected_refl[$];    // predicted results in order of transfer
  bit         failed;
  bit         stim_done;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned idle_cycles;

  fresnel_reflectance_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .in_i   (in_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  // bitwise integer square root, floor
  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // |a - b| / (a + b) as a truncated q30 quotient, restoring division
  function automatic longint unsigned amplitude_q30(longint unsigned a, longint unsigned b);
    longint unsigned n;
    longint unsigned den;
    longint unsigned q;
    n   = (a >= b) ? a - b : b - a;
    den = a + b;
    if (den == 0) return 64'd1 << Wq;
    q = 0;
    if (n >= den) begin
      q = 1;
      n -= den;
    end
    for (int i = 0; i < Wq; i++) begin
      n <<= 1;
      q <<= 1;
      if (n >= den) begin
        n -= den;
        q |= 1;
      end
    end
    return q;
  endfunction

  // expected reflectance for one command
  function automatic frefl_res_t fresnel_predict(frefl_in_t c);
    longint          dp;
    longint          lim;
    bit              exiting;
    longint unsigned one, cosi, c2, sin_i, eta, eta_i, eta_t, sin_t, s2, cos_t;
    longint unsigned rs, rp, sum, sat, refl;
    frefl_res_t      r;
    one = 64'd1 << Wq;
    lim = 64'sd1 << (2 * FracBitsDef);
    dp  = longint'(c.dir_x) * longint'(c.normal_x) + longint'(c.dir_y) * longint'(c.normal_y)
        + longint'(c.dir_z) * longint'(c.normal_z);
    if (dp > lim) dp = lim;
    if (dp < -lim) dp = -lim;
    exiting = dp > 0;
    cosi = (dp < 0) ? longint'(-dp) : longint'(dp);
    cosi = cosi << (Wq - 2 * FracBitsDef);
    if (cosi > one) cosi = one;
    c2    = (cosi * cosi) >> Wq;
    sin_i = int_sqrt((one - c2) << Wq);
    eta   = (c.ior == 0) ? 64'd1 : 64'(c.ior);
    eta_i = exiting ? eta : 64'(EtaOne);
    eta_t = exiting ? 64'(EtaOne) : eta;
    sat   = 64'd1 << FracBitsDef;
    if (sat > 64'hFFFF) sat = 64'hFFFF;
    sin_t = (sin_i * eta_i) / eta_t;
    if (sin_t >= one) begin
      r.reflectance    = sat[15:0];
      r.total_internal = 1'b1;
      return r;
    end
    s2    = (sin_t * sin_t) >> Wq;
    cos_t = int_sqrt((one - s2) << Wq);
    rs    = amplitude_q30(eta_t * cosi, eta_i * cos_t);
    rp    = amplitude_q30(eta_i * cosi, eta_t * cos_t);
    sum   = rs * rs + rp * rp;
    refl  = (sum + (64'd1 << (60 - FracBitsDef))) >> (61 - FracBitsDef);
    if (refl > sat) refl = sat;
    r.reflectance    = refl[15:0];
    r.total_internal = 1'b0;
    return r;
  endfunction

  function automatic frefl_in_t make_cmd(int dx, int dy, int dz, int nx, int ny, int nz,
                                         int unsigned eta);
    frefl_in_t c;
    c.dir_x = 16'(dx); c.dir_y = 16'(dy); c.dir_z = 16'(dz);
    c.normal_x = 16'(nx); c.normal_y = 16'(ny); c.normal_z = 16'(nz);
    c.ior = 16'(eta);
    return c;
  endfunction

  // random vector component, large when it lies on the dominant axis
  function automatic logic [15:0] comp_rand(bit dominant);
    int v;
    v = dominant ? int'($urandom_range(32767, 16000)) : int'($urandom_range(16000, 0));
    if ($urandom_range(1, 0)) v = -v;
    return 16'(v);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // command driver: bursts of transfers with random gaps between them
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start      <= 1'b0;
      in_i       <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (start && !busy) expected_refl.push_back(fresnel_predict(in_i));
      if (start && busy) begin
        // not taken yet, hold the command
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        start    <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        in_i  <= pending_cmds.pop_front();
        start <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(40, 1);
          // a third of bursts run straight into the next one
          gap_left   <= ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(12, 1);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result monitor: every strobe is checked against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_refl.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual refl=%0d tir=%0b",
                 $realtime, res_o.reflectance, res_o.total_internal);
        failed <= 1'b1;
      end else begin
        frefl_res_t e;
        e = expected_refl.pop_front();
        if (res_o.reflectance !== e.reflectance) begin
          $display("%0t: reflectance mismatch, expected %0d, actual %0d",
                   $realtime, e.reflectance, res_o.reflectance);
          failed <= 1'b1;
        end
        if (res_o.total_internal !== e.total_internal) begin
          $display("%0t: total_internal mismatch, expected %0b, actual %0b",
                   $realtime, e.total_internal, res_o.total_internal);
          failed <= 1'b1;
        end
      end
    end
  end

  // watchdog on cycles with neither a command nor a result transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || stim_done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int unsigned eta;
    failed    = 1'b0;
    stim_done = 1'b0;
    rst_ni    = 1'b0;

    // directed: normal incidence, exiting, grazing, clamp, ior extremes, tir
    pending_cmds.push_back(make_cmd(-32768, 0, 0, 32767, 0, 0, 6144));
    pending_cmds.push_back(make_cmd(32767, 0, 0, 32767, 0, 0, 6144));
    pending_cmds.push_back(make_cmd(0, 32767, 0, 32767, 0, 0, 6144));  // zero cosine
    pending_cmds.push_back(make_cmd(0, -32768, 0, 32767, 0, 0, 65535));
    pending_cmds.push_back(make_cmd(-32768, -32768, -32768, -32768, -32768, -32768, 6144));
    pending_cmds.push_back(make_cmd(-32768, -32768, -32768, 32767, 32767, 32767, 4096));
    pending_cmds.push_back(make_cmd(-23170, 23170, 0, 32767, 0, 0, 0));  // zero ior
    pending_cmds.push_back(make_cmd(-23170, 23170, 0, 32767, 0, 0, 1));
    pending_cmds.push_back(make_cmd(-23170, 23170, 0, 32767, 0, 0, 65535));
    pending_cmds.push_back(make_cmd(23170, 23170, 0, 32767, 0, 0, 6144));  // exiting, tir
    pending_cmds.push_back(make_cmd(5000, 32000, 0, 32767, 0, 0, 6144));   // grazing exit
    pending_cmds.push_back(make_cmd(32767, 0, 0, 32767, 0, 0, 0));
    pending_cmds.push_back(make_cmd(32767, 0, 0, 32767, 0, 0, 65535));
    pending_cmds.push_back(make_cmd(16384, 0, 0, 32767, 0, 0, 4096));
    pending_cmds.push_back(make_cmd(-1, -1, -1, 1, 1, 1, 4096));
    pending_cmds.push_back(make_cmd(32767, 32767, 32767, -1, -1, -1, 8192));
    pending_cmds.push_back(make_cmd(0, 0, 0, 0, 0, 0, 6144));

    // random: mostly near-unit geometry with glass-like indices, some raw noise
    for (int i = 0; i < 1650; i++) begin
      frefl_in_t c;
      case ($urandom_range(9, 0))
        0, 1: begin
          c = frefl_in_t'(112'({$urandom, $urandom, $urandom, $urandom}));
        end
        default: begin
          int ax;
          ax = $urandom_range(2, 0);
          c.dir_x    = comp_rand(ax == 0);
          c.dir_y    = comp_rand(ax == 1);
          c.dir_z    = comp_rand(ax == 2);
          ax = $urandom_range(2, 0);
          c.normal_x = comp_rand(ax == 0);
          c.normal_y = comp_rand(ax == 1);
          c.normal_z = comp_rand(ax == 2);
          eta = ($urandom_range(3, 0) == 0) ? $urandom_range(65535, 0)
                                            : $urandom_range(12288, 4096);
          c.ior = 16'(eta);
        end
      endcase
      pending_cmds.push_back(c);
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_cmds.size() == 0 && !start);
    wait (expected_refl.size() == 0);
    stim_done = 1'b1;
    repeat (Drain) @(posedge clk_i);

    if (!failed && expected_refl.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
sv/frefl_pkg.sv
sv/frefl_sqrt_pipe.sv
sv/frefl_div_pipe.sv
sv/fresnel_reflectance_unit.sv
tb/sv/tb_fresnel_reflectance_unit.sv
